// ----- hdl/positional_list_insert_delete_unit_macros.svh -----
// Assertion macros for the positional list unit.
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PLID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plid assertion failed");

// Next-cycle implication, checked out of reset.
`define PLID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plid assertion failed");

`else

`define PLID_ASSERT_IMP(label, ante, cons)
`define PLID_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/plid_pkg.sv -----
// Package: types and constants of the positional list unit.
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

  localparam int DEPTH     = 16;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 5;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  position;
    logic [31:0] element;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  count;
    logic        is_full;
    logic        is_empty;
  } out_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos_idx;
    logic [ELEM_BITS-1:0]   elem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/plid_cell.sv -----
// One slot of the list row: holds, loads, or takes a neighbor's entry.
`timescale 1ns / 1ps
`default_nettype none

module plid_cell (
  input  wire logic                          clk,
  input  wire plid_pkg::cell_ctrl_t          ctrl,
  input  wire logic [plid_pkg::IDX_W-1:0]     my_idx,
  input  wire logic [plid_pkg::ELEM_BITS-1:0] lower_q,
  input  wire logic [plid_pkg::ELEM_BITS-1:0] upper_q,
  output logic      [plid_pkg::ELEM_BITS-1:0] q
);
  import plid_pkg::*;

  logic [ELEM_BITS-1:0] slot_r;
  logic [ELEM_BITS-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    case (ctrl.op)
      CELL_INS: begin
        if (my_idx == ctrl.pos_idx) begin
          slot_nxt = ctrl.elem;
        end else if (my_idx > ctrl.pos_idx) begin
          slot_nxt = lower_q;
        end
      end
      CELL_DEL: begin
        if (my_idx >= ctrl.pos_idx) begin
          slot_nxt = upper_q;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign q = slot_r;

endmodule

`default_nettype wire

// ----- hdl/positional_list_insert_delete_unit.sv -----
// Each accepted request's result is loaded into the output register at the end of its transfer cycle.
// Throughput: one request per cycle when not stalled; the whole cell row shifts in that cycle.
// Input is stalled only while a result waits in the output register.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// Slot contents are not reset; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_insert_delete_unit_macros.svh"

module positional_list_insert_delete_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire plid_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output plid_pkg::out_t      out_data
);
  import plid_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;
  cell_ctrl_t           ctrl;
  logic [ELEM_BITS-1:0] slot_q [DEPTH];
  logic                 acc;
  logic [CMP_W-1:0]     pos_x, cnt_x;
  logic                 is_ins, is_dr, pos_zero, full_now, empty_now;
  logic                 ins_ok, del_ok, rd_ok;
  status_t              status;
  logic [ELEM_BITS-1:0] rd_elem;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  assign pos_x     = CMP_W'(in_data.position);
  assign cnt_x     = CMP_W'(count_r);
  assign pos_zero  = (in_data.position == '0);
  assign full_now  = (count_r == CNT_W'(DEPTH));
  assign empty_now = (count_r == '0);
  assign is_ins    = (in_data.req_type == REQ_INSERT);
  assign is_dr     = (in_data.req_type == REQ_DELETE) || (in_data.req_type == REQ_READ);

  assign ins_ok = is_ins && !full_now && !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
  assign del_ok = (in_data.req_type == REQ_DELETE) && !empty_now && !pos_zero &&
                  (pos_x <= cnt_x);
  assign rd_ok  = (in_data.req_type == REQ_READ) && !empty_now && !pos_zero &&
                  (pos_x <= cnt_x);

  always_comb begin
    if (is_ins) begin
      status = full_now ? ST_FULL : (ins_ok ? ST_OK : ST_BADPOS);
    end else if (is_dr) begin
      status = empty_now ? ST_EMPTY : ((del_ok || rd_ok) ? ST_OK : ST_BADPOS);
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    ctrl.pos_idx = IDX_W'(in_data.position - 5'd1);
    ctrl.elem    = ELEM_BITS'(in_data.element);
    ctrl.op      = CELL_HOLD;
    if (acc && ins_ok) begin
      ctrl.op = CELL_INS;
    end else if (acc && del_ok) begin
      ctrl.op = CELL_DEL;
    end
  end

  // Row of cells; the low end sees zero below it, the high end sees its own entry above it.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_BITS-1:0] lower_q, upper_q;
      if (g == 0) begin : g_lo
        assign lower_q = '0;
      end else begin : g_lo
        assign lower_q = slot_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_hi
        assign upper_q = slot_q[g];
      end else begin : g_hi
        assign upper_q = slot_q[g+1];
      end
      plid_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .my_idx  (IDX_W'(g)),
        .lower_q (lower_q),
        .upper_q (upper_q),
        .q       (slot_q[g])
      );
    end
  endgenerate

  assign rd_elem = slot_q[ctrl.pos_idx];

  always_comb begin
    count_nxt = count_r;
    if (acc) begin
      if (ins_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (del_ok) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (in_data.req_type == REQ_CLEAR) begin
        count_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (acc) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = status;
      out_nxt.read_data = rd_ok ? 32'(rd_elem) : 32'd0;
      out_nxt.count     = 5'(count_nxt);
      out_nxt.is_full   = (count_nxt == CNT_W'(DEPTH));
      out_nxt.is_empty  = (count_nxt == '0);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLID_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH))
  `PLID_ASSERT_NEXT(a_ins_count, acc && ins_ok, count_r == $past(count_r) + CNT_W'(1))
  `PLID_ASSERT_NEXT(a_acc_result, acc, out_valid_r && (out_r.count == 5'(count_r)))
  `PLID_ASSERT_IMP(a_flags, out_valid_r, out_r.is_empty == (out_r.count == 5'd0))

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the positional list unit: directed table, then random traffic checked by a predictor.
`timescale 1ns / 1ps

module testbench;
  import plid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned PHASE_LEN = 120;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT = 900;

  typedef struct {
    req_t        kind;
    logic [4:0]  pos;
    logic [31:0] elem;
    int          reps;
    bit          typed;
    out_t        want;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Predictor state: the list as the block should hold it.
  logic [ELEM_BITS-1:0] list_mem [DEPTH];
  int                   list_cnt;

  out_t        expected_q[$];
  step_row_t   dir_rows[$];
  int unsigned n_mismatch;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned cycles;
  int unsigned kind_seen [4];
  int unsigned status_seen [4];
  int unsigned full_hits;
  bit          calm;
  bit          hold_req;

  positional_list_insert_delete_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic out_t apply_request(in_t rq);
    out_t r;
    int   p;
    r = '0;
    r.status = ST_OK;
    p = rq.position;
    case (req_t'(rq.req_type))
      REQ_INSERT: begin
        if (list_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p == 0 || p > list_cnt + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int j = list_cnt; j >= p; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = rq.element;
          list_cnt++;
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (list_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (p == 0 || p > list_cnt) begin
          r.status = ST_BADPOS;
        end else if (req_t'(rq.req_type) == REQ_READ) begin
          r.read_data = list_mem[p-1];
        end else begin
          for (int j = p; j < list_cnt; j++) list_mem[j-1] = list_mem[j];
          list_cnt--;
        end
      end
      default: begin
        list_cnt = 0;
      end
    endcase
    r.count    = list_cnt[4:0];
    r.is_full  = (list_cnt == DEPTH);
    r.is_empty = (list_cnt == 0);
    return r;
  endfunction

  function automatic out_t res(status_t st, logic [31:0] rd, int cnt);
    out_t r;
    r.status    = st;
    r.read_data = rd;
    r.count     = cnt[4:0];
    r.is_full   = (cnt == DEPTH);
    r.is_empty  = (cnt == 0);
    return r;
  endfunction

  function automatic void add_row(req_t kind, logic [4:0] pos, logic [31:0] elem, int reps,
                                  bit typed, out_t want);
    step_row_t row;
    row.kind  = kind;
    row.pos   = pos;
    row.elem  = elem;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Mostly zero, some short, a few long; none at all in calm phases.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Random request shaped by the predicted count; ins_w biases toward fill or drain.
  function automatic in_t random_request(int unsigned ins_w);
    in_t         rq;
    int unsigned r;
    int          hi;
    r = $urandom_range(0, 99);
    rq.element = $urandom();
    if (r < 3) rq.req_type = REQ_CLEAR;
    else if (r < 3 + ins_w) rq.req_type = REQ_INSERT;
    else if (r < 3 + ins_w + (97 - ins_w) / 2) rq.req_type = REQ_DELETE;
    else rq.req_type = REQ_READ;
    if (req_t'(rq.req_type) == REQ_INSERT) hi = (list_cnt < DEPTH) ? list_cnt + 1 : DEPTH;
    else hi = (list_cnt > 0) ? list_cnt : 1;
    if ($urandom_range(0, 99) < 85) rq.position = $urandom_range(1, hi);
    else rq.position = $urandom_range(0, 31);
    return rq;
  endfunction

  task automatic send_request(input in_t rq, input bit typed, input out_t want);
    out_t        pred;
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    pred = apply_request(rq);
    expected_q.push_back(typed ? want : pred);
    kind_seen[rq.req_type]++;
    if (list_cnt == DEPTH) full_hits++;
    n_sent++;
  endtask

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        n_mismatch++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        status_seen[out_data.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_mismatch++;
        end
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
          n_mismatch++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          n_mismatch++;
        end
        if (out_data.is_full !== want.is_full) begin
          $error("is_full: expected %b, got %b", want.is_full, out_data.is_full);
          n_mismatch++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, got %b", want.is_empty, out_data.is_empty);
          n_mismatch++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    in_t         rq;
    step_row_t   row;
    int unsigned ins_w;
    bit          hold_done;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cycles     = 0;
    n_mismatch = 0;
    n_sent     = 0;
    n_checked  = 0;
    full_hits  = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    list_cnt   = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (status_seen[k]) status_seen[k] = 0;

    add_row(REQ_READ,    5'd1,  32'h0,          1,  1, res(ST_EMPTY, 32'h0, 0));
    add_row(REQ_DELETE,  5'd0,  32'h0,          1,  1, res(ST_EMPTY, 32'h0, 0));
    add_row(REQ_INSERT,  5'd0,  32'hFFFF_FFFF,  1,  1, res(ST_BADPOS, 32'h0, 0));
    add_row(REQ_INSERT,  5'd2,  32'hFFFF_FFFF,  1,  1, res(ST_BADPOS, 32'h0, 0));
    add_row(REQ_INSERT,  5'd1,  32'hFFFF_FFFF,  1,  1, res(ST_OK, 32'h0, 1));
    add_row(REQ_INSERT,  5'd1,  32'h0,          1,  1, res(ST_OK, 32'h0, 2));
    add_row(REQ_INSERT,  5'd3,  32'hA5A5_5A5A,  1,  0, '0);
    add_row(REQ_READ,    5'd0,  32'h0,          1,  1, res(ST_BADPOS, 32'h0, 3));
    add_row(REQ_READ,    5'd4,  32'h0,          1,  1, res(ST_BADPOS, 32'h0, 3));
    add_row(REQ_READ,    5'd1,  32'h0,          1,  1, res(ST_OK, 32'h0, 3));
    add_row(REQ_READ,    5'd2,  32'h0,          1,  1, res(ST_OK, 32'hFFFF_FFFF, 3));
    add_row(REQ_INSERT,  5'd31, 32'h1234_5678,  1,  1, res(ST_BADPOS, 32'h0, 3));
    add_row(REQ_DELETE,  5'd2,  32'h0,          1,  0, '0);
    add_row(REQ_DELETE,  5'd3,  32'h0,          1,  1, res(ST_BADPOS, 32'h0, 2));
    add_row(REQ_CLEAR,   5'd5,  32'hDEAD_BEEF,  1,  1, res(ST_OK, 32'h0, 0));
    add_row(REQ_INSERT,  5'd1,  32'h8000_0001,  15, 0, '0);
    add_row(REQ_INSERT,  5'd16, 32'h7FFF_FFFE,  1,  0, '0);
    add_row(REQ_INSERT,  5'd1,  32'h5555_AAAA,  1,  1, res(ST_FULL, 32'h0, 16));
    add_row(REQ_INSERT,  5'd0,  32'h5555_AAAA,  1,  1, res(ST_FULL, 32'h0, 16));
    add_row(REQ_READ,    5'd16, 32'h0,          1,  0, '0);
    add_row(REQ_READ,    5'd17, 32'h0,          1,  1, res(ST_BADPOS, 32'h0, 16));
    add_row(REQ_DELETE,  5'd16, 32'h0,          1,  0, '0);
    add_row(REQ_DELETE,  5'd1,  32'h0,          1,  0, '0);
    add_row(REQ_CLEAR,   5'd0,  32'h0,          1,  1, res(ST_OK, 32'h0, 0));
    add_row(REQ_DELETE,  5'd1,  32'h0,          1,  1, res(ST_EMPTY, 32'h0, 0));
    add_row(REQ_CLEAR,   5'd31, 32'hFFFF_FFFF,  1,  1, res(ST_OK, 32'h0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        rq.req_type = row.kind;
        rq.position = row.pos;
        rq.element  = row.elem ^ k;
        send_request(rq, row.typed, row.want);
      end
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Alternate fill-heavy and drain-heavy phases; every third one runs without gaps.
      ins_w = ((i / PHASE_LEN) % 2 == 0) ? 62 : 25;
      calm  = ((i / PHASE_LEN) % 3 == 2);
      if (!hold_done && i >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      rq = random_request(ins_w);
      send_request(rq, 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (insert %0d, delete %0d, read %0d, clear %0d), %0d results checked",
             n_sent, kind_seen[REQ_INSERT], kind_seen[REQ_DELETE], kind_seen[REQ_READ],
             kind_seen[REQ_CLEAR], n_checked);
    $display("Statuses ok %0d, full %0d, empty %0d, bad position %0d; list full %0d times",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS], full_hits);
    if (n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
